/* hw/rtl/chtd_pkg.sv */
// Shared types and constants for the chunked transfer decoder.
// No dependencies; imported by chtd_parser and chunked_transfer_decoder.
`default_nettype none

package chtd_pkg;

  // characters seen on a size line
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  // verdict on a finished size line
  typedef enum logic [1:0] {
    LINE_SKIP,
    LINE_ZERO,
    LINE_DATA
  } line_t;

  // one result as it leaves the parser
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       body_done;
    logic       done_kind;
  } chtd_result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0_0000;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/chtd_parser.sv */
// Chunk framing state and per-byte decode logic of the chunked transfer decoder.
// Depends on chtd_pkg.
`default_nettype none

module chtd_parser #(
  parameter int SIZE_DIGITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire logic [7:0]            step_byte,
  input  wire logic                  step_last,
  output chtd_pkg::chtd_result_t     res
);
  import chtd_pkg::*;

  localparam int SW = 4 * SIZE_DIGITS;
  localparam int CW = $clog2(SIZE_DIGITS + 2);
  localparam logic [CW-1:0] CNT_MAX  = CW'(SIZE_DIGITS);
  localparam logic [CW-1:0] CNT_OVER = CW'(SIZE_DIGITS + 1);

  typedef enum logic [2:0] {
    MODE_SIZE,
    MODE_TAIL,
    MODE_DATA,
    MODE_SKIP,
    MODE_DONE
  } mode_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS
  } phase_t;

  mode_t          mode_r,  mode_nxt;
  phase_t         phase_r, phase_nxt;
  logic [SW-1:0]  acc_r,   acc_nxt;
  logic [CW-1:0]  cnt_r,   cnt_nxt;
  logic [SW-1:0]  left_r,  left_nxt;

  logic [4:0]     hex;
  logic           is_hex;
  logic [SW-1:0]  acc_add;
  logic [CW-1:0]  cnt_add;
  logic           lf;

  function automatic line_t judge(input phase_t ph, input logic [CW-1:0] cnt,
                                  input logic [SW-1:0] acc);
    line_t r;
    if (ph == PH_PREFIX && cnt == '0)       r = LINE_ZERO;
    else if (cnt == '0 || cnt > CNT_MAX)     r = LINE_SKIP;
    else if (acc == '0)                      r = LINE_ZERO;
    else                                     r = LINE_DATA;
    return r;
  endfunction

  assign hex    = hex_decode(step_byte);
  assign is_hex = hex[4];
  assign lf     = (step_byte == CH_LF);

  // one more digit; past the limit the count just pins at overflow
  always_comb begin
    if (cnt_r < CNT_MAX) begin
      acc_add = (acc_r << 4) | SW'(hex[3:0]);
      cnt_add = cnt_r + 1'b1;
    end else begin
      acc_add = acc_r;
      cnt_add = CNT_OVER;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    res       = '0;

    case (mode_r)
      MODE_DATA: begin
        res.data_valid = 1'b1;
        res.data_byte  = step_byte;
        left_nxt       = left_r - 1'b1;
        if (left_r == SW'(1)) mode_nxt = MODE_SKIP;
      end
      MODE_SKIP: begin
        if (lf) begin
          mode_nxt  = MODE_SIZE;
          phase_nxt = PH_LEAD;
          acc_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      MODE_SIZE, MODE_TAIL: begin
        if (lf) begin
          case (judge(phase_r, cnt_r, acc_r))
            LINE_ZERO: begin
              res.body_done = 1'b1;
              mode_nxt      = MODE_DONE;
            end
            LINE_DATA: begin
              left_nxt = acc_r;
              mode_nxt = MODE_DATA;
            end
            default: mode_nxt = MODE_SIZE;
          endcase
          phase_nxt = PH_LEAD;
          acc_nxt   = '0;
          cnt_nxt   = '0;
        end else if (mode_r == MODE_SIZE) begin
          case (phase_r)
            PH_LEAD: begin
              if (is_blank(step_byte)) begin
                // leading whitespace is dropped
              end else if (is_hex) begin
                phase_nxt = (step_byte == CH_ZERO) ? PH_ZERO : PH_DIGITS;
                acc_nxt   = acc_add;
                cnt_nxt   = cnt_add;
              end else begin
                mode_nxt = MODE_TAIL;
              end
            end
            PH_ZERO: begin
              if (step_byte == CH_X_LO || step_byte == CH_X_UP) begin
                phase_nxt = PH_PREFIX;
                acc_nxt   = '0;
                cnt_nxt   = '0;
              end else if (is_hex) begin
                phase_nxt = PH_DIGITS;
                acc_nxt   = acc_add;
                cnt_nxt   = cnt_add;
              end else begin
                mode_nxt = MODE_TAIL;
              end
            end
            default: begin
              if (is_hex) begin
                phase_nxt = PH_DIGITS;
                acc_nxt   = acc_add;
                cnt_nxt   = cnt_add;
              end else begin
                mode_nxt = MODE_TAIL;
              end
            end
          endcase
        end
      end
      default: ;
    endcase

    if (step_last) begin
      // end of stream: report an early end unless the body already closed;
      // an open size line is judged as it stands
      if (mode_r != MODE_DONE && !res.body_done) begin
        res.body_done = 1'b1;
        res.done_kind = 1'b1;
        if ((mode_nxt == MODE_SIZE || mode_nxt == MODE_TAIL) &&
            judge(phase_nxt, cnt_nxt, acc_nxt) == LINE_ZERO)
          res.done_kind = 1'b0;
      end
      mode_nxt  = MODE_SIZE;
      phase_nxt = PH_LEAD;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      left_nxt  = '0;
    end

    if (!step_en) res = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SIZE;
      phase_r <= PH_LEAD;
      acc_r   <= '0;
      cnt_r   <= '0;
      left_r  <= '0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
    end
  end

  a_data_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DATA |-> left_r != '0)
    else $error("chunk payload mode with zero bytes left");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_OVER)
    else $error("digit count past overflow mark");

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && step_last |=> mode_r == MODE_SIZE && cnt_r == '0 && left_r == '0)
    else $error("parser not rearmed after final byte");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !step_last && mode_r == MODE_DONE |=> mode_r == MODE_DONE)
    else $error("left finished state before final byte");

  a_payload_mode: assert property (@(posedge clk) disable iff (!rst_n)
    res.data_valid |-> mode_r == MODE_DATA && step_en)
    else $error("payload byte outside chunk data");

endmodule

`default_nettype wire

/* hw/rtl/chunked_transfer_decoder.sv */
// Top level of the chunked transfer decoder: input register, parser, result register.
// Depends on chtd_pkg and chtd_parser.
//
//   channel  direction  handshake            payload
//   in_      request in  in_valid / in_stall   in_byte, in_last
//   out_     result out  out_valid / out_stall out_data_byte, out_data_valid,
//                                              out_body_done, out_done_kind
//
// One byte per cycle sustained while out_stall stays low; a result is offered on out_ once its
// byte has passed the input register and then the result register.
// The parser state and its one-byte decode sit between those two registers.
// rst_n is synchronous; the parser comes up waiting for a size line, no clearing pass.
// While the result register is full and out_stall is high, a byte held in the input
// register waits and in_stall goes high; bytes that give no result still need that slot.
`default_nettype none

module chunked_transfer_decoder #(
  parameter int SIZE_DIGITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_data_byte,
  output logic            out_data_valid,
  output logic            out_body_done,
  output logic            out_done_kind
);
  import chtd_pkg::*;

  logic         in_v_r;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  logic         out_v_r;
  chtd_result_t out_r;
  chtd_result_t res;
  logic         step_en;
  logic         in_take;

  // the held byte moves on whenever the result slot is free or being drained
  assign step_en  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !step_en;
  assign in_take  = in_valid && !in_stall;

  chtd_parser #(.SIZE_DIGITS(SIZE_DIGITS)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .step_byte (in_byte_r),
    .step_last (in_last_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (step_en) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_en) begin
      out_v_r <= res.data_valid || res.body_done;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) out_r <= res;
  end

  assign out_valid      = out_v_r;
  assign out_data_byte  = out_r.data_byte;
  assign out_data_valid = out_r.data_valid;
  assign out_body_done  = out_r.body_done;
  assign out_done_kind  = out_r.done_kind;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stall |=> out_v_r && $stable(out_r))
    else $error("stalled result overwritten");

  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.data_valid || out_r.body_done)
    else $error("empty result presented");

  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !step_en |=> in_v_r && $stable(in_byte_r) && $stable(in_last_r))
    else $error("held request lost before decode");

endmodule

`default_nettype wire
